[hw/rtl/lstk_pkg.sv]
`timescale 1ns / 1ps

package lstk_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_PUSH     = 3'd1,
        OP_POP      = 3'd2,
        OP_TRAVERSE = 3'd3,
        OP_PEEK     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    // front-to-back command channel
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } t_result;

    // back-to-output-queue write channel
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_chan;

    function automatic logic is_known_op(input logic [2:0] code);
        is_known_op = (code == OP_CLEAR) || (code == OP_PUSH) || (code == OP_POP)
                   || (code == OP_TRAVERSE) || (code == OP_PEEK);
    endfunction

endpackage

[hw/rtl/lstk_front.sv]
`timescale 1ns / 1ps

module lstk_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lstk_pkg::WORD_W-1:0]     s_axis_tdata,
    input  logic [7:0]                      s_axis_tuser,
    output lstk_pkg::t_cmd_chan             o_cmd,
    input  logic                            i_cmd_take
);

    lstk_pkg::t_cmd r_q [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_occ;
    logic           push;
    logic           pop;

    assign s_axis_tready = (r_occ != 2'd2);
    // unknown selectors are swallowed here and never reach the back end
    assign push = s_axis_tvalid && s_axis_tready && lstk_pkg::is_known_op(s_axis_tuser[2:0]);
    assign pop  = i_cmd_take && (r_occ != 2'd0);

    assign o_cmd.valid = (r_occ != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr].op    <= lstk_pkg::t_op'(s_axis_tuser[2:0]);
            r_q[r_wr_ptr].value <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_occ    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_occ <= r_occ + 2'd1;
                2'b01:   r_occ <= r_occ - 2'd1;
                default: r_occ <= r_occ;
            endcase
        end
    end

endmodule

[hw/rtl/lstk_back.sv]
`timescale 1ns / 1ps

module lstk_back #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lstk_pkg::t_cmd_chan  i_cmd,
    output logic                 o_cmd_take,
    input  logic [2:0]           i_free,
    output lstk_pkg::t_res_chan  o_res
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [lstk_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [lstk_pkg::WORD_W-1:0] r_rd_data;

    logic [CW-1:0] r_count, n_count;
    logic          r_trav,  n_trav;
    logic [AW-1:0] r_trav_idx, n_trav_idx;

    logic              r_p1_valid, n_p1_valid;
    lstk_pkg::t_status r_p1_status, n_p1_status;
    logic              r_p1_last, n_p1_last;
    logic              r_p1_mem, n_p1_mem;

    logic          credit;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] cnt_m1, cnt_m2;
    logic          empty, full;

    // a slot must remain for the beat already in flight
    assign credit = (i_free > {2'b00, r_p1_valid});
    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);
    assign empty  = (r_count == '0);
    assign full   = (r_count == CW'(DEPTH));

    always_comb begin
        o_cmd_take  = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = cnt_m1[AW-1:0];
        wr_en       = 1'b0;
        n_count     = r_count;
        n_trav      = r_trav;
        n_trav_idx  = r_trav_idx;
        n_p1_valid  = 1'b0;
        n_p1_status = lstk_pkg::ST_OK;
        n_p1_last   = 1'b1;
        n_p1_mem    = 1'b0;
        if (r_trav) begin
            if (credit) begin
                rd_en      = 1'b1;
                rd_addr    = r_trav_idx;
                n_p1_valid = 1'b1;
                n_p1_mem   = 1'b1;
                n_p1_last  = (r_trav_idx == '0);
                n_trav_idx = r_trav_idx - AW'(1);
                if (r_trav_idx == '0) n_trav = 1'b0;
            end
        end else if (i_cmd.valid && credit) begin
            o_cmd_take = 1'b1;
            n_p1_valid = 1'b1;
            unique case (i_cmd.cmd.op)
                lstk_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                lstk_pkg::OP_PUSH: begin
                    if (full) begin
                        n_p1_status = lstk_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                lstk_pkg::OP_POP: begin
                    if (empty) begin
                        n_p1_status = lstk_pkg::ST_EMPTY;
                    end else begin
                        rd_en    = 1'b1;
                        n_p1_mem = 1'b1;
                        n_count  = cnt_m1;
                    end
                end
                lstk_pkg::OP_PEEK: begin
                    if (empty) begin
                        n_p1_status = lstk_pkg::ST_EMPTY;
                    end else begin
                        rd_en    = 1'b1;
                        n_p1_mem = 1'b1;
                    end
                end
                lstk_pkg::OP_TRAVERSE: begin
                    if (empty) begin
                        n_p1_status = lstk_pkg::ST_EMPTY;
                    end else begin
                        // top word now, the rest streams from the walk counter
                        rd_en      = 1'b1;
                        n_p1_mem   = 1'b1;
                        n_p1_last  = (r_count == CW'(1));
                        n_trav     = (r_count != CW'(1));
                        n_trav_idx = cnt_m2[AW-1:0];
                    end
                end
                default: begin
                    n_p1_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_count[AW-1:0]] <= i_cmd.cmd.value;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_p1_status <= n_p1_status;
        r_p1_last   <= n_p1_last;
        r_p1_mem    <= n_p1_mem;
        r_trav_idx  <= n_trav_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_trav     <= 1'b0;
            r_p1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_trav     <= n_trav;
            r_p1_valid <= n_p1_valid;
        end
    end

    assign o_res.valid      = r_p1_valid;
    assign o_res.res.status = r_p1_status;
    assign o_res.res.word   = r_p1_mem ? r_rd_data : '0;
    assign o_res.res.last   = r_p1_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trav |-> (CW'(r_trav_idx) < r_count))
        else $error("traverse index outside stored entries");

    a_no_cmd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trav |-> !o_cmd_take)
        else $error("command taken during traverse");

    a_count_frozen_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trav && $past(r_trav)) |-> $stable(r_count))
        else $error("count changed during traverse");

endmodule

[hw/rtl/lstk_outq.sv]
`timescale 1ns / 1ps

module lstk_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lstk_pkg::t_res_chan             i_res,
    output logic [2:0]                      o_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lstk_pkg::WORD_W-1:0]     m_axis_tdata,
    output logic [7:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    lstk_pkg::t_result r_q [4];
    logic [1:0]        r_wr_ptr, r_rd_ptr;
    logic [2:0]        r_occ;
    logic              pop;
    lstk_pkg::t_result head;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign o_free        = 3'd4 - r_occ;
    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = (r_occ != 3'd0);
    assign m_axis_tdata  = head.word;
    assign m_axis_tuser  = {6'd0, head.status};
    assign m_axis_tlast  = head.last;

    always_ff @(posedge i_clk) begin
        if (i_res.valid) r_q[r_wr_ptr] <= i_res.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_occ    <= 3'd0;
        end else begin
            if (i_res.valid) r_wr_ptr <= r_wr_ptr + 2'd1;
            if (pop)         r_rd_ptr <= r_rd_ptr + 2'd1;
            case ({i_res.valid, pop})
                2'b10:   r_occ <= r_occ + 3'd1;
                2'b01:   r_occ <= r_occ - 3'd1;
                default: r_occ <= r_occ;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && r_occ == 3'd4) |-> pop)
        else $error("result beat written into full queue");

endmodule

[hw/rtl/lifo_stack_with_traverse.sv]
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit words, up to DEPTH entries.
// Input stream: s_axis_tuser[2:0] selects clear/push/pop/traverse/peek,
// s_axis_tdata carries the word to push. Selectors 5..7 are dropped silently.
// Output stream: one beat per result; m_axis_tuser[1:0] is the status
// (ok, overflow, empty), m_axis_tdata the popped/peeked/traversed word or
// zero, m_axis_tlast marks the final beat caused by an input beat.
// Clear, push, pop and peek yield one beat; traverse yields one beat per
// stored word, top to bottom (one beat if the stack is empty).
// Input beats wait in the command queue; results are registered in the back
// end, then in the result queue. Throughput is one input beat per cycle for
// clear, push, pop and peek while the result queue has room; traverse holds
// the back end till each word is read through the storage's single read port.
// Reset empties the stack and both queues; stored words are not cleared.
// When the receiver stalls, a 4-beat result queue fills, the back end halts,
// the 2-entry command queue fills and s_axis_tready drops.
module lifo_stack_with_traverse #(
    parameter int unsigned DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [7:0]  s_axis_tuser,   // [2:0] func, [7:3] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_word
    output logic [7:0]  m_axis_tuser,   // [1:0] status, [7:2] zero
    output logic        m_axis_tlast    // last_result
);

    lstk_pkg::t_cmd_chan cmd;
    lstk_pkg::t_res_chan res;
    logic                cmd_take;
    logic [2:0]          free;

    lstk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .i_cmd_take    (cmd_take)
    );

    lstk_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_cmd_take (cmd_take),
        .i_free     (free),
        .o_res      (res)
    );

    lstk_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (res),
        .o_free        (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
